[rtl/assert_macros.svh]
// Assertion macros shared by the multiset combination unrank RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define MCU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcu assertion failed");

// next-cycle implication, disabled in reset
`define MCU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcu assertion failed");

`endif

[rtl/mcu_pkg.sv]
// Shared types and constants of the multiset combination unrank block.
// No dependencies.
`timescale 1ns / 1ps
package mcu_pkg;

  localparam logic [7:0] CFG_MULT  = 8'd0;
  localparam logic [7:0] CFG_TYPES = 8'd1;
  localparam logic [7:0] CFG_PICK  = 8'd2;

  typedef struct packed {
    logic load_rank;
    logic load_counts;
    logic wc_dec;
    logic wc_zero;
    logic sum_clr;
    logic sum_add;
    logic acc_clr;
    logic acc_take;
    logic rank_sub;
    logic ram_we;
    logic ram_src_sum;
    logic init_one;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic upto_gt;
    logic rank_ge;
  } dp_sts_t;

endpackage

[rtl/mcu_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mcu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mcu_datapath.sv]
// Datapath: working counts, rank, accumulators and the partial-sum RAM.
// Depends on mcu_pkg and mcu_ram.
`timescale 1ns / 1ps
module mcu_datapath #(
  parameter int MAX_TYPES  = 16,
  parameter int COUNT_BITS = 4,
  parameter int MAX_PICK   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [31:0]                      in_rank,
  input  logic [63:0]                      mult,
  input  logic [$clog2(MAX_TYPES+1)-1:0]   nt,
  input  logic [$clog2(MAX_TYPES)-1:0]     wc_idx,
  input  logic [$clog2(MAX_PICK+1)-1:0]    ram_addr,
  input  mcu_pkg::dp_cmd_t                 cmd,
  output mcu_pkg::dp_sts_t                 sts,
  output logic [COUNT_BITS-1:0]            cnt_f
);

  localparam int AW = $clog2(MAX_PICK + 1);

  logic [COUNT_BITS-1:0] wc_r [MAX_TYPES];
  logic [63:0] sum_r;
  logic [63:0] acc_r;
  logic [31:0] rank_r;
  logic [63:0] rdata;
  logic [63:0] wdata;
  logic [63:0] upto;

  assign cnt_f = wc_r[wc_idx];
  assign wdata = cmd.ram_src_sum ? sum_r : {63'd0, cmd.init_one};
  assign upto  = acc_r + rdata;

  always_comb begin
    sts.cnt_zero = (cnt_f == '0);
    sts.upto_gt  = upto > {32'd0, rank_r};
    sts.rank_ge  = {32'd0, rank_r} >= rdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_counts) begin
      for (int t = 0; t < MAX_TYPES; t++) begin
        wc_r[t] <= (t < int'(nt)) ? mult[t*COUNT_BITS +: COUNT_BITS] : '0;
      end
    end else if (cmd.wc_dec) begin
      wc_r[wc_idx] <= wc_r[wc_idx] - 1'b1;
    end else if (cmd.wc_zero) begin
      wc_r[wc_idx] <= '0;
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + rdata;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_take) begin
      acc_r <= upto;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
    end else if (cmd.load_rank) begin
      rank_r <= in_rank;
    end else if (cmd.rank_sub) begin
      rank_r <= rank_r - acc_r[31:0];
    end
  end

  mcu_ram #(
    .WIDTH (64),
    .DEPTH (MAX_PICK + 1)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (ram_addr[AW-1:0]),
    .wdata (wdata),
    .raddr (ram_addr[AW-1:0]),
    .rdata (rdata)
  );

endmodule

[rtl/mcu_ctrl.sv]
// Controller: sequences totals, type scans and the counting passes.
// Depends on mcu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mcu_ctrl #(
  parameter int MAX_TYPES  = 16,
  parameter int COUNT_BITS = 4,
  parameter int MAX_PICK   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [$clog2(MAX_TYPES+1)-1:0]   nt,
  input  logic [$clog2(MAX_PICK+1)-1:0]    k,
  input  logic                             in_valid,
  output logic                             in_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [4:0]                       out_position,
  output logic [3:0]                       out_type_index,
  output logic                             out_last,
  output logic                             out_rank_error,
  output logic [$clog2(MAX_TYPES)-1:0]     wc_idx,
  output logic [$clog2(MAX_PICK+1)-1:0]    ram_addr,
  output mcu_pkg::dp_cmd_t                 cmd,
  input  mcu_pkg::dp_sts_t                 sts,
  input  logic [COUNT_BITS-1:0]            cnt_f
);

  localparam int KW  = $clog2(MAX_PICK + 1);
  localparam int NTW = $clog2(MAX_TYPES + 1);
  localparam int TW  = $clog2(MAX_TYPES);
  localparam int HW  = COUNT_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_TYPE, S_RD, S_ACC, S_WR, S_FIN_RD, S_FIN, S_SCAN, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [KW-1:0]  m_r, m_nxt, dpj_r, dpj_nxt, ii_r, ii_nxt;
  logic [NTW-1:0] t_r, t_nxt, sj_r, sj_nxt;
  logic [HW-1:0]  h_r, h_nxt;
  logic [COUNT_BITS-1:0] f_r, f_nxt;
  logic [TW-1:0]  chosen_r, chosen_nxt;
  logic           total_ph_r, total_ph_nxt;
  logic           ov_r, ov_nxt, last_r, last_nxt, err_r, err_nxt;
  logic [4:0]     pos_r, pos_nxt;
  logic [3:0]     typ_r, typ_nxt;
  logic [HW-1:0]  h_inc;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = ov_r;
  assign out_position   = pos_r;
  assign out_type_index = typ_r;
  assign out_last       = last_r;
  assign out_rank_error = err_r;
  assign h_inc          = h_r + 1'b1;
  assign wc_idx         = (state_r == S_TYPE) ? TW'(t_r) : TW'(sj_r);

  always_comb begin
    case (state_r)
      S_RD:     ram_addr = dpj_r - KW'(h_r);
      S_FIN_RD: ram_addr = m_r;
      default:  ram_addr = dpj_r;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    m_nxt        = m_r;
    dpj_nxt      = dpj_r;
    ii_nxt       = ii_r;
    t_nxt        = t_r;
    sj_nxt       = sj_r;
    h_nxt        = h_r;
    f_nxt        = f_r;
    chosen_nxt   = chosen_r;
    total_ph_nxt = total_ph_r;
    ov_nxt       = ov_r;
    last_nxt     = last_r;
    err_nxt      = err_r;
    pos_nxt      = pos_r;
    typ_nxt      = typ_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_rank   = 1'b1;
          cmd.load_counts = 1'b1;
          total_ph_nxt    = 1'b1;
          m_nxt           = k;
          dpj_nxt         = '0;
          if (k == '0) begin
            ov_nxt    = 1'b1;
            err_nxt   = 1'b1;
            last_nxt  = 1'b1;
            pos_nxt   = '0;
            typ_nxt   = '0;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.ram_we   = 1'b1;
        cmd.init_one = (dpj_r == '0);
        dpj_nxt      = dpj_r + 1'b1;
        if (dpj_r == m_r) begin
          t_nxt     = '0;
          state_nxt = S_TYPE;
        end
      end
      S_TYPE: begin
        if (t_r == nt || m_r == '0) begin
          state_nxt = S_FIN_RD;
        end else begin
          f_nxt       = cnt_f;
          dpj_nxt     = m_r;
          h_nxt       = '0;
          cmd.sum_clr = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.sum_add = 1'b1;
        h_nxt       = h_inc;
        if (h_inc <= {1'b0, f_r} && 8'(h_inc) <= 8'(dpj_r)) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.ram_we      = 1'b1;
        cmd.ram_src_sum = 1'b1;
        dpj_nxt         = dpj_r - 1'b1;
        if (dpj_r == KW'(1)) begin
          t_nxt     = t_r + 1'b1;
          state_nxt = S_TYPE;
        end else begin
          cmd.sum_clr = 1'b1;
          h_nxt       = '0;
          state_nxt   = S_RD;
        end
      end
      S_FIN_RD: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (total_ph_r) begin
          if (sts.rank_ge) begin
            ov_nxt    = 1'b1;
            err_nxt   = 1'b1;
            last_nxt  = 1'b1;
            pos_nxt   = '0;
            typ_nxt   = '0;
            state_nxt = S_EMIT;
          end else begin
            cmd.load_counts = 1'b1;
            cmd.acc_clr     = 1'b1;
            total_ph_nxt    = 1'b0;
            ii_nxt          = '0;
            sj_nxt          = '0;
            chosen_nxt      = '0;
            state_nxt       = S_SCAN;
          end
        end else if (sts.upto_gt) begin
          cmd.rank_sub = 1'b1;
          chosen_nxt   = TW'(sj_r);
          ov_nxt       = 1'b1;
          err_nxt      = 1'b0;
          last_nxt     = (ii_r + 1'b1 == k);
          pos_nxt      = 5'(ii_r);
          typ_nxt      = 4'(TW'(sj_r));
          state_nxt    = S_EMIT;
        end else begin
          cmd.acc_take = 1'b1;
          cmd.wc_zero  = 1'b1;
          sj_nxt       = sj_r + 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sj_r == nt) begin
          ov_nxt    = 1'b1;
          err_nxt   = 1'b0;
          last_nxt  = (ii_r + 1'b1 == k);
          pos_nxt   = 5'(ii_r);
          typ_nxt   = 4'(chosen_r);
          state_nxt = S_EMIT;
        end else if (sts.cnt_zero) begin
          sj_nxt = sj_r + 1'b1;
        end else begin
          cmd.wc_dec = 1'b1;
          m_nxt      = k - ii_r - 1'b1;
          dpj_nxt    = '0;
          state_nxt  = S_INIT;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          ov_nxt = 1'b0;
          if (last_r || err_r) begin
            state_nxt = S_IDLE;
          end else begin
            ii_nxt      = ii_r + 1'b1;
            sj_nxt      = NTW'(chosen_r);
            chosen_nxt  = '0;
            cmd.acc_clr = 1'b1;
            state_nxt   = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ov_r       <= 1'b0;
      chosen_r   <= '0;
      total_ph_r <= 1'b0;
      ii_r       <= '0;
      sj_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      ov_r       <= ov_nxt;
      chosen_r   <= chosen_nxt;
      total_ph_r <= total_ph_nxt;
      ii_r       <= ii_nxt;
      sj_r       <= sj_nxt;
    end
    m_r    <= m_nxt;
    dpj_r  <= dpj_nxt;
    t_r    <= t_nxt;
    h_r    <= h_nxt;
    f_r    <= f_nxt;
    last_r <= last_nxt;
    err_r  <= err_nxt;
    pos_r  <= pos_nxt;
    typ_r  <= typ_nxt;
  end

  `MCU_ASSERT_SAME(a_err_is_last, ov_r && err_r, last_r)
  `MCU_ASSERT_SAME(a_rd_in_range, state_r == S_RD, h_r <= {1'b0, f_r} && dpj_r != '0)
  `MCU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

[rtl/multiset_combination_unrank_top.sv]
// Multiset combination unranking: takes a rank, emits one word per position
// with the chosen type, the last one flagged; a rank out of range or an empty
// pick gives one error word. Input is taken only while idle, and each word
// waits for out_ready. The work is done in counting passes over the
// partial-sum RAM. A pass over m sums clears m+1 entries, then for each of
// number_of_types types reads, per sum j from m down to 1, min(count, j)+1
// entries and writes the sum back. The total takes one pass with m = pick_size
// and each candidate type tried takes one with m = positions still to fill;
// rejected types are zeroed, so an item needs at most about pick_size +
// number_of_types passes. Configuration is taken at once.
// Depends on mcu_pkg, mcu_ctrl, mcu_datapath and mcu_ram.
`timescale 1ns / 1ps
module multiset_combination_unrank_top #(
  parameter int MAX_TYPES  = 16,
  parameter int COUNT_BITS = 4,
  parameter int MAX_PICK   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_position,
  output logic [3:0]  out_type_index,
  output logic        out_last,
  output logic        out_rank_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int KW  = $clog2(MAX_PICK + 1);
  localparam int NTW = $clog2(MAX_TYPES + 1);
  localparam int TW  = $clog2(MAX_TYPES);

  logic [63:0] mult_r;
  logic [4:0]  types_r;
  logic [5:0]  pick_r;
  logic [NTW-1:0] nt;
  logic [KW-1:0]  k;
  logic [TW-1:0]  wc_idx;
  logic [KW-1:0]  ram_addr;
  logic [COUNT_BITS-1:0] cnt_f;
  mcu_pkg::dp_cmd_t cmd;
  mcu_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;
  assign nt = (8'(types_r) > 8'(MAX_TYPES)) ? NTW'(MAX_TYPES) : NTW'(types_r);
  assign k  = (8'(pick_r) > 8'(MAX_PICK)) ? KW'(MAX_PICK) : KW'(pick_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r  <= '0;
      types_r <= 5'd1;
      pick_r  <= 6'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        mcu_pkg::CFG_MULT:  mult_r  <= cfg_data;
        mcu_pkg::CFG_TYPES: types_r <= cfg_data[4:0];
        mcu_pkg::CFG_PICK:  pick_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  mcu_ctrl #(
    .MAX_TYPES (MAX_TYPES),
    .COUNT_BITS(COUNT_BITS),
    .MAX_PICK  (MAX_PICK)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .nt            (nt),
    .k             (k),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_position  (out_position),
    .out_type_index(out_type_index),
    .out_last      (out_last),
    .out_rank_error(out_rank_error),
    .wc_idx        (wc_idx),
    .ram_addr      (ram_addr),
    .cmd           (cmd),
    .sts           (sts),
    .cnt_f         (cnt_f)
  );

  mcu_datapath #(
    .MAX_TYPES (MAX_TYPES),
    .COUNT_BITS(COUNT_BITS),
    .MAX_PICK  (MAX_PICK)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rank (in_rank),
    .mult    (mult_r),
    .nt      (nt),
    .wc_idx  (wc_idx),
    .ram_addr(ram_addr),
    .cmd     (cmd),
    .sts     (sts),
    .cnt_f   (cnt_f)
  );

endmodule
